// ===== hw/rtl/istk_pkg.sv =====
package istk_pkg;

  localparam int COUNT_W = 7;
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int STATUS_W = 2;
  localparam int POS_W = 6;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // capture request, update fill level, launch first read
    logic scan;    // advance the top-down search by one entry
    logic finish;  // load the result register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

// ===== hw/rtl/istk_datapath.sv =====
module istk_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  istk_pkg::ctrl_cmd_t                  cmd,
  output istk_pkg::dp_status_t                 stat,
  input  logic                                 cfg_we,
  input  logic [istk_pkg::COUNT_W-1:0]         cfg_wdata,
  input  logic [istk_pkg::KIND_W-1:0]          in_kind,
  input  logic [istk_pkg::WORD_W-1:0]          in_value,
  output logic [istk_pkg::STATUS_W-1:0]        res_status,
  output logic [istk_pkg::WORD_W-1:0]          res_data,
  output logic [istk_pkg::POS_W-1:0]           res_position,
  output logic [istk_pkg::COUNT_W-1:0]         res_count,
  output logic                                 res_is_empty,
  output logic                                 res_is_full
);
  import istk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = (AW > COUNT_W) ? AW : COUNT_W;
  localparam int PW = (AW > POS_W) ? AW : POS_W;
  localparam logic [COUNT_W-1:0] CAP_LIMIT =
    (DEPTH > 127) ? 7'd127 : COUNT_W'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic [COUNT_W-1:0] capacity;
  logic [COUNT_W-1:0] fill;
  logic [COUNT_W-1:0] left;
  logic [KIND_W-1:0]  kind;
  logic [WORD_W-1:0]  value;
  logic               refused;
  logic               cmp_valid;
  logic [AW-1:0]      cmp_addr;

  logic [COUNT_W-1:0] cap_eff;
  logic               push_ok;
  logic               nonempty;
  logic               hit;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      top_addr;
  logic [AW-1:0]      left_addr;
  logic [AW-1:0]      fill_addr;
  logic [EW-1:0]      top_ext;
  logic [EW-1:0]      left_ext;
  logic [EW-1:0]      fill_ext;
  logic [PW-1:0]      pos_ext;

  assign cap_eff  = (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
  assign push_ok  = fill < cap_eff;
  assign nonempty = fill != '0;

  assign fill_ext  = EW'(fill);
  assign top_ext   = EW'(fill) - EW'(1);
  assign left_ext  = EW'(left) - EW'(1);
  assign fill_addr = fill_ext[AW-1:0];
  assign top_addr  = top_ext[AW-1:0];
  assign left_addr = left_ext[AW-1:0];

  assign hit = cmp_valid && (rd_data == value);
  assign stat.scan_done = hit || !cmp_valid;

  always_comb begin
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = left_addr;
    if (cmd.accept) begin
      rd_addr = top_addr;
      wr_en   = (in_kind == KIND_PUSH) && push_ok;
      rd_en   = nonempty && ((in_kind == KIND_POP) || (in_kind == KIND_PEEK) ||
                             (in_kind == KIND_SEARCH));
    end else if (cmd.scan) begin
      rd_en = (left != '0) && !hit;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_addr] <= in_value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      fill      <= '0;
      left      <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      cmp_valid <= rd_en;
      if (cmd.accept) begin
        unique case (in_kind)
          KIND_PUSH:   if (push_ok) fill <= fill + COUNT_W'(1);
          KIND_POP:    if (nonempty) fill <= fill - COUNT_W'(1);
          KIND_CLEAR:  fill <= '0;
          KIND_SEARCH: if (nonempty) left <= fill - COUNT_W'(1);
          default:     ;
        endcase
      end else if (cmd.scan && rd_en) begin
        left <= left - COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cmp_addr <= rd_addr;
    end
    if (cmd.accept) begin
      kind  <= in_kind;
      value <= in_value;
      case (in_kind) inside
        KIND_PUSH:             refused <= !push_ok;
        KIND_POP, KIND_PEEK:   refused <= !nonempty;
        default:               refused <= 1'b0;
      endcase
    end
  end

  assign pos_ext = PW'(cmp_addr);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_count    <= fill;
      res_is_empty <= !nonempty;
      res_is_full  <= !push_ok;
      res_data     <= '0;
      res_position <= '0;
      res_status   <= ST_DONE;
      if (refused) begin
        res_status <= ST_REFUSED;
      end else if ((kind == KIND_POP) || (kind == KIND_PEEK)) begin
        res_data <= rd_data;
      end else if (kind == KIND_SEARCH) begin
        if (hit) begin
          res_position <= pos_ext[POS_W-1:0];
        end else begin
          res_status <= ST_NOT_FOUND;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/istk_ctrl.sv =====
module istk_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [istk_pkg::KIND_W-1:0] in_kind,
  output logic                        out_valid,
  input  logic                        out_ready,
  output istk_pkg::ctrl_cmd_t         cmd,
  input  istk_pkg::dp_status_t        stat
);
  import istk_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_SEND;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (in_kind == KIND_SEARCH) ? S_SCAN : S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.finish = 1'b1;
        state_next = S_SEND;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          cmd.finish = 1'b1;
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/int_stack_with_search_unit.sv =====
// Timing: after a request is accepted, S_WAIT loads the result registers and S_SEND
// offers them; a search instead stays in S_SCAN, reading one entry per cycle from the
// top down through the single registered memory read port, until a hit or the end.
// Flow: one request at a time; the next is accepted in the cycle after
// the result transaction.
// Reset (rst, synchronous): stack empty, capacity 64; entries are not cleared.
module int_stack_with_search_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,   // capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // value
  input  logic [2:0]  s_tuser,     // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,     // data, position, count, is_empty, is_full, zero pad
  output logic [1:0]  m_tuser      // status
);
  import istk_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  logic [WORD_W-1:0]  data;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic               is_full;

  istk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  istk_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_kind      (s_tuser),
    .in_value     (s_tdata),
    .res_status   (m_tuser),
    .res_data     (data),
    .res_position (position),
    .res_count    (count),
    .res_is_empty (is_empty),
    .res_is_full  (is_full)
  );

  assign m_tdata = {1'b0, is_full, is_empty, count, position, data};

endmodule
